### src/bpl_pkg.sv
// Shared types and constants for the bounded priority list.
package bpl_pkg;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EVICT  = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam logic [3:0] LIMIT_RESET = 4'd5;

  typedef struct packed {
    logic [7:0]  pri;
    logic [15:0] dur;
    logic [15:0] tag;
  } entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic   ins;
    logic   rem;
    logic   take;
    entry_t new_e;
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  new_priority;
    logic [15:0] new_duration;
    logic [15:0] new_tag;
    logic [2:0]  remove_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [7:0]  out_priority;
    logic [15:0] out_duration;
    logic [15:0] out_tag;
    logic [3:0]  entry_count;
  } out_item_t;

endpackage

### src/bpl_chan_if.sv
// Valid/ready channel interfaces: operation input, result output, limit write.
interface bpl_in_if;
  logic              valid;
  logic              ready;
  bpl_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpl_out_if;
  logic               valid;
  logic               ready;
  bpl_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpl_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/bpl_cell.sv
// One list slot: holds an entry, shifts toward or away from the head.
module bpl_cell #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bpl_pkg::cell_cmd_t  cmd,
  input  logic [CW-1:0]       n_eff,     // slots in play for the insert compare
  input  logic [CW-1:0]       sel,       // position that leaves the list
  input  logic [CW-1:0]       cnt_nxt,   // count after this beat
  input  logic                ge_prev,   // left neighbor stays put on insert
  input  bpl_pkg::entry_t     prev_e,
  input  bpl_pkg::entry_t     next_e,
  output logic                ge,
  output logic                vld_q,
  output bpl_pkg::entry_t     e_q,
  output bpl_pkg::entry_t     take_e
);
  import bpl_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  entry_t e_r, e_nxt;
  logic   vld_r, vld_nxt;

  assign ge     = (MY_IDX < n_eff) && (e_r.pri > cmd.new_e.pri);
  assign e_q    = e_r;
  assign vld_q  = vld_r;
  assign take_e = (cmd.take && (MY_IDX == sel)) ? e_r : '0;

  always_comb begin
    e_nxt   = e_r;
    vld_nxt = vld_r;
    if (cmd.ins) begin
      if (!ge) begin
        e_nxt = ge_prev ? cmd.new_e : prev_e;
      end
      vld_nxt = MY_IDX < cnt_nxt;
    end else if (cmd.rem) begin
      if (MY_IDX >= sel) begin
        e_nxt = next_e;
      end
      vld_nxt = MY_IDX < cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

### src/bounded_priority_list_unit.sv
// Top level of the bounded priority list: decode, cell row, result register.
//
//   channel | dir | beat carries                                  | ready
//   in_ch   | in  | operation, priority, duration, tag, position  | result slot free
//   out_ch  | out | status, leaving entry, entry count            | from consumer
//   cfg_ch  | in  | entry_limit (4 bits)                          | always high
//
// One operation per cycle while in_ch is not stalled: every cell compares against the broadcast entry
// and shifts in the same cycle, result lands in the output register next edge.
// in_ch stalls only while a result waits and out_ch.ready is low.
// Synchronous active-low reset empties the list and sets the limit to 5.
module bounded_priority_list_unit #(
  parameter int DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  bpl_in_if.sink    in_ch,
  bpl_out_if.source out_ch,
  bpl_cfg_if.sink   cfg_ch
);
  import bpl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  // Limit register
  logic [3:0] lim_r;

  // Count and result register
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_vld_r;
  out_item_t     out_data_r;

  // Decode
  logic          fire;
  logic          evict;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] sel;
  cell_cmd_t     cmd;
  logic [1:0]    status;

  // Cell row
  entry_t           cell_e    [DEPTH];
  entry_t           cell_take [DEPTH];
  logic [DEPTH-1:0] cell_ge;
  logic [DEPTH-1:0] cell_vld;
  entry_t           take_or;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_vld_r || out_ch.ready;
  assign fire         = in_ch.valid && in_ch.ready;

  // Limit of 0 acts as 1, limit above DEPTH acts as DEPTH (count never exceeds DEPTH).
  assign evict = (cnt_r != '0) && ((8'(cnt_r) >= 8'(lim_r)) || (cnt_r == FULL));

  always_comb begin
    cmd         = '0;
    cmd.new_e   = '{pri: in_ch.data.new_priority,
                    dur: in_ch.data.new_duration,
                    tag: in_ch.data.new_tag};
    n_eff       = cnt_r;
    sel         = '0;
    cnt_nxt     = cnt_r;
    status      = ST_OK;
    case (in_ch.data.operation)
      OP_INSERT: begin
        if (evict) begin
          // Last slot leaves first, insert then sorts into the rest.
          n_eff    = cnt_r - 1'b1;
          sel      = cnt_r - 1'b1;
          cmd.take = fire;
          status   = ST_EVICT;
        end
        cmd.ins = fire;
        cnt_nxt = n_eff + 1'b1;
      end
      OP_POP: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end else begin
          cmd.rem  = fire;
          cmd.take = fire;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end else if (8'(in_ch.data.remove_position) >= 8'(cnt_r)) begin
          status = ST_BADPOS;
        end else begin
          sel      = CW'(in_ch.data.remove_position);
          cmd.rem  = fire;
          cmd.take = fire;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   ge_prev;
    entry_t prev_e;
    entry_t next_e;

    if (i == 0) begin : g_head
      assign ge_prev = 1'b1;
      assign prev_e  = '0;
    end else begin : g_mid
      assign ge_prev = cell_ge[i-1];
      assign prev_e  = cell_e[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = cell_e[i+1];
    end

    bpl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .n_eff   (n_eff),
      .sel     (sel),
      .cnt_nxt (cnt_nxt),
      .ge_prev (ge_prev),
      .prev_e  (prev_e),
      .next_e  (next_e),
      .ge      (cell_ge[i]),
      .vld_q   (cell_vld[i]),
      .e_q     (cell_e[i]),
      .take_e  (cell_take[i])
    );
  end

  // Only the selected cell drives its entry, the rest give zero.
  always_comb begin
    take_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      take_or = take_or | cell_take[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r     <= LIMIT_RESET;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        lim_r <= cfg_ch.data;
      end
      if (fire) begin
        cnt_r     <= cnt_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.status       <= status;
      out_data_r.out_valid    <= cmd.take;
      out_data_r.out_priority <= take_or.pri;
      out_data_r.out_duration <= take_or.dur;
      out_data_r.out_tag      <= take_or.tag;
      out_data_r.entry_count  <= 4'(cnt_nxt);
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

`ifndef ASSERT_OFF
  a_cnt_matches_vld: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == int'(cnt_r))
    else $error("count disagrees with cell valid bits");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("count beyond depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r && (out_data_r.entry_count == 4'(cnt_r)))
    else $error("result missing or count mismatch after beat");

  a_evict_reports: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.status == ST_EVICT) |-> out_data_r.out_valid)
    else $error("eviction without leaving entry");

  a_error_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ((out_data_r.status == ST_EMPTY) || (out_data_r.status == ST_BADPOS))
      |-> !out_data_r.out_valid)
    else $error("error status carries an entry");
`endif

endmodule

### verif/bpl_checker.sv
// Result checker for the bounded priority list: predicts each result beat and compares it.
`timescale 1ns / 1ps
module bpl_checker #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bpl_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bpl_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [3:0]         cfg_data,
  output int                 fail_count,
  output int                 outstanding
);
  import bpl_pkg::*;

  entry_t      list_slots [DEPTH];
  int unsigned held;
  logic [3:0]  limit_reg;
  out_item_t   expected_results [$];

  // zero acts as one, anything past the row acts as the row size
  function automatic int unsigned eff_limit();
    int unsigned lim;
    lim = limit_reg;
    if (lim == 0) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    return lim;
  endfunction

  function automatic void take_entry(int unsigned pos, inout out_item_t r);
    r.out_valid    = 1'b1;
    r.out_priority = list_slots[pos].pri;
    r.out_duration = list_slots[pos].dur;
    r.out_tag      = list_slots[pos].tag;
    for (int unsigned i = pos; i + 1 < held; i++) list_slots[i] = list_slots[i + 1];
    held--;
  endfunction

  function automatic out_item_t apply_list_op(in_item_t op);
    out_item_t   r;
    int unsigned at;
    r        = '0;
    r.status = ST_OK;
    case (op.operation)
      OP_INSERT: begin
        if (held >= eff_limit() && held > 0) begin
          take_entry(held - 1, r);
          r.status = ST_EVICT;
        end
        at = 0;
        while (at < held && list_slots[at].pri > op.new_priority) at++;
        for (int unsigned i = held; i > at; i--) list_slots[i] = list_slots[i - 1];
        list_slots[at].pri = op.new_priority;
        list_slots[at].dur = op.new_duration;
        list_slots[at].tag = op.new_tag;
        held++;
      end
      OP_POP: begin
        if (held == 0) r.status = ST_EMPTY;
        else take_entry(0, r);
      end
      OP_REMOVE: begin
        if (held == 0) r.status = ST_EMPTY;
        else if (op.remove_position >= held) r.status = ST_BADPOS;
        else take_entry(op.remove_position, r);
      end
      default: ;
    endcase
    r.entry_count = 4'(held);
    return r;
  endfunction

  function automatic int field_diff(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    int        errs;
    out_item_t want;
    errs = 0;
    if (!rst_n) begin
      held      = 0;
      limit_reg = LIMIT_RESET;
      expected_results.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0h", $time, out_data);
          errs++;
        end else begin
          want = expected_results.pop_front();
          errs += field_diff("status", want.status, out_data.status);
          errs += field_diff("out_valid", want.out_valid, out_data.out_valid);
          errs += field_diff("out_priority", want.out_priority, out_data.out_priority);
          errs += field_diff("out_duration", want.out_duration, out_data.out_duration);
          errs += field_diff("out_tag", want.out_tag, out_data.out_tag);
          errs += field_diff("entry_count", want.entry_count, out_data.entry_count);
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (in_valid && in_ready) expected_results.push_back(apply_list_op(in_data));
      fail_count  <= fail_count + errs;
      outstanding <= expected_results.size();
    end
  end

endmodule

### verif/tb.sv
// Testbench top for the bounded priority list: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import bpl_pkg::*;

  // Operation code the block treats as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Length of the receiver hold-off that backs the result register up.
  localparam int LONG_HOLD = 60;
  localparam int PHASE_BEATS = 115;

  logic clk;
  logic rst_n;

  bpl_in_if  in_ch ();
  bpl_out_if out_ch ();
  bpl_cfg_if cfg_ch ();

  int chk_fails;
  int chk_outstanding;

  // Idle percentages for each side, and the hold-off request token.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_token  = 0;

  bounded_priority_list_unit #(.DEPTH(8)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bpl_checker #(.DEPTH(8)) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .fail_count  (chk_fails),
    .outstanding (chk_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side. A new hold token starts a long stretch with ready low,
  // counted here; otherwise ready drops at the current idle rate. The
  // sender keeps offering during the hold, so the one-deep result register
  // fills and in_ch.ready must fall.
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one operation beat, after a random number of idle cycles, and
  // return at the edge where it is taken. Valid stays high back to back
  // when no gap is drawn.
  task automatic send_op(in_item_t op);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= op;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_fields(logic [1:0] opc, logic [7:0] pri, logic [15:0] dur,
                             logic [15:0] tag, logic [2:0] pos);
    in_item_t op;
    op.operation       = opc;
    op.new_priority    = pri;
    op.new_duration    = dur;
    op.new_tag         = tag;
    op.remove_position = pos;
    send_op(op);
  endtask

  // Stop offering and let every expected result drain before touching the limit.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(logic [3:0] lim);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= lim;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly inserts so the list fills and evicts; priorities often drawn
  // from a tiny range so equal-priority ordering gets exercised.
  function automatic in_item_t random_op();
    in_item_t    op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) op.operation = OP_INSERT;
    else if (pick < 75) op.operation = OP_POP;
    else if (pick < 95) op.operation = OP_REMOVE;
    else op.operation = OP_UNUSED;
    if ($urandom_range(2) == 0) op.new_priority = 8'($urandom_range(3));
    else op.new_priority = 8'($urandom);
    op.new_duration    = 16'($urandom);
    op.new_tag         = 16'($urandom);
    op.remove_position = 3'($urandom);
    return op;
  endfunction

  initial begin : stimulus
    int lim_plan [3][4];
    lim_plan = '{'{8, 1, 15, 3}, '{0, 6, 8, 2}, '{4, 15, 1, 7}};
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= LIMIT_RESET;
    tx_idle_pct  <= 35;
    rx_idle_pct  <= 86;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset limit of five.
    send_fields(OP_POP,    8'd0,   16'h0000, 16'h0000, 3'd0);   // pop on empty
    send_fields(OP_REMOVE, 8'd0,   16'h0000, 16'h0000, 3'd0);   // remove on empty
    send_fields(OP_UNUSED, 8'd0,   16'h0000, 16'h0000, 3'd0);   // no-op code, empty
    send_fields(OP_INSERT, 8'd0,   16'h0000, 16'h0000, 3'd0);   // insert into empty
    send_fields(OP_INSERT, 8'd255, 16'hffff, 16'hffff, 3'd7);
    send_fields(OP_INSERT, 8'd255, 16'h0001, 16'h0001, 3'd0);   // ties go ahead
    send_fields(OP_INSERT, 8'd128, 16'h1234, 16'h0002, 3'd0);
    send_fields(OP_INSERT, 8'd128, 16'h5678, 16'h0003, 3'd0);   // list now full
    send_fields(OP_INSERT, 8'd1,   16'h00aa, 16'h0004, 3'd0);   // evicts the zero
    send_fields(OP_INSERT, 8'd0,   16'h00bb, 16'h0005, 3'd0);   // evicts, lands last
    send_fields(OP_REMOVE, 8'd0,   16'h0000, 16'h0000, 3'd7);   // past count
    send_fields(OP_REMOVE, 8'd0,   16'h0000, 16'h0000, 3'd5);   // just past count
    send_fields(OP_REMOVE, 8'd0,   16'h0000, 16'h0000, 3'd4);   // last entry
    send_fields(OP_REMOVE, 8'd0,   16'h0000, 16'h0000, 3'd0);   // head
    send_fields(OP_POP,    8'd0,   16'h0000, 16'h0000, 3'd0);
    send_fields(OP_UNUSED, 8'hff,  16'hffff, 16'hffff, 3'd7);   // no-op, all ones
    send_fields(OP_REMOVE, 8'd0,   16'h0000, 16'h0000, 3'd1);
    send_fields(OP_POP,    8'd0,   16'h0000, 16'h0000, 3'd0);   // last one out
    send_fields(OP_POP,    8'd0,   16'h0000, 16'h0000, 3'd0);   // empty again

    // Random part: three idle regimes, four limits each. Going from eight
    // down to one leaves a full list above the new limit.
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          tx_idle_pct <= 35;
          rx_idle_pct <= 86;
        end
        1: begin
          tx_idle_pct <= 86;
          rx_idle_pct <= 35;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int p = 0; p < 4; p++) begin
        wait_idle();
        write_limit(4'(lim_plan[m][p]));
        if (p == 1) hold_token <= hold_token + 1;
        repeat (PHASE_BEATS) send_op(random_op());
      end
    end

    // Drain and settle, then give the verdict.
    wait_idle();
    repeat (4) @(posedge clk);
    if (chk_fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
src/bpl_pkg.sv
src/bpl_chan_if.sv
src/bpl_cell.sv
src/bounded_priority_list_unit.sv
verif/bpl_checker.sv
verif/tb.sv
